>>> rtl/core/matrix_multiply_accumulate_macros.svh
// Assertion helpers shared by the RTL.
`ifndef MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define MMA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define MMA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`MMA_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

>>> rtl/core/mma_pkg.sv
package mma_pkg;

	// Default sizes of the element stores.
	localparam int MAX_DIM_DEF      = 64;
	localparam int ELEMENT_BITS_DEF = 16;

	// Fixed field widths.
	localparam int IDX_W   = 6;
	localparam int DIM_W   = 7;
	localparam int VAL_W   = 16;
	localparam int ACCIN_W = 32;
	localparam int ACC_W   = 40;
	localparam int CMD_W   = 2;
	localparam int REG_W   = 2;

	// Stream beat widths, padded to whole bytes.
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 56;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [REG_W-1:0] reg_idx_t;

	// Command codes.
	localparam cmd_t CMD_LOAD_A  = 2'd0;
	localparam cmd_t CMD_LOAD_B  = 2'd1;
	localparam cmd_t CMD_COMPUTE = 2'd2;
	localparam cmd_t CMD_UNUSED  = 2'd3;

	// Configuration register indexes.
	localparam reg_idx_t REG_ROWS_OF_A    = 2'd0;
	localparam reg_idx_t REG_COLUMNS_OF_B = 2'd1;
	localparam reg_idx_t REG_INNER_DEPTH  = 2'd2;

endpackage

>>> rtl/core/matrix_multiply_accumulate.sv
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: command; tdata: row, column, element, acc_in
// m_*      out  m_tvalid/m_tready  tdata: result_row, result_column, result_value
// cfg_*    in   cfg_we             cfg_index selects register, cfg_data is the value
//
// A load, the unused command or a compute outside C leaves the block idle. A
// compute beat inside C runs K products (K = inner_depth, capped at MAX_DIM), or
// none when K is zero: one shared multiplier does one k per cycle behind a
// registered store read and a product register, then the result moves to the
// output register. Input is not ready while a compute runs or its result waits
// for the output register. The stores are not cleared at reset.
module matrix_multiply_accumulate
	import mma_pkg::*;
#(
	parameter int MAX_DIM      = MAX_DIM_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
	input  logic [IN_DATA_W-1:0]  s_tdata,   // row_index, column_index, element_value,
	                                         // accumulator_in, zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // result_row, result_column,
	                                         // result_value, zero pad
	input  logic                  cfg_we,
	input  logic [REG_W-1:0]      cfg_index,
	input  logic [DIM_W-1:0]      cfg_data
);

`include "matrix_multiply_accumulate_macros.svh"

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_DIM + 1);
	localparam int EW    = (CW > DIM_W) ? CW : DIM_W;
	localparam int PW    = 2 * ELEMENT_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// Input beat fields
	logic        [IDX_W-1:0]   in_row;
	logic        [IDX_W-1:0]   in_col;
	logic signed [VAL_W-1:0]   in_elem;
	logic signed [ACCIN_W-1:0] in_acc;
	cmd_t                      in_cmd;

	assign in_cmd  = s_tuser;
	assign in_row  = s_tdata[IDX_W-1:0];
	assign in_col  = s_tdata[2*IDX_W-1:IDX_W];
	assign in_elem = s_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
	assign in_acc  = s_tdata[2*IDX_W+VAL_W+ACCIN_W-1:2*IDX_W+VAL_W];

	// Configuration registers
	logic [DIM_W-1:0] rows_q, cols_q, depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_W'(64);
			cols_q  <= DIM_W'(64);
			depth_q <= DIM_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_OF_A:    rows_q  <= cfg_data;
				REG_COLUMNS_OF_B: cols_q  <= cfg_data;
				REG_INNER_DEPTH:  depth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Dimensions capped at the store size
	logic [EW-1:0] m_eff, n_eff, k_eff, dim_max;

	assign dim_max = EW'(MAX_DIM);
	assign m_eff   = (EW'(rows_q)  > dim_max) ? dim_max : EW'(rows_q);
	assign n_eff   = (EW'(cols_q)  > dim_max) ? dim_max : EW'(cols_q);
	assign k_eff   = (EW'(depth_q) > dim_max) ? dim_max : EW'(depth_q);

	// Accept decode
	logic [1:0]  state_q;
	logic        accept;
	logic        idx_in_store;
	logic        c_in_range;
	logic        do_load_a, do_load_b, do_compute;
	logic [AW-1:0] load_addr, row_base;
	logic signed [ELEMENT_BITS-1:0] elem_ext;

	assign s_tready     = (state_q == ST_IDLE);
	assign accept       = s_tvalid && s_tready;
	assign idx_in_store = (EW'(in_row) < dim_max) && (EW'(in_col) < dim_max);
	assign c_in_range   = (EW'(in_row) < m_eff) && (EW'(in_col) < n_eff);
	assign do_load_a    = accept && (in_cmd == CMD_LOAD_A) && idx_in_store;
	assign do_load_b    = accept && (in_cmd == CMD_LOAD_B) && idx_in_store;
	assign do_compute   = accept && (in_cmd == CMD_COMPUTE) && c_in_range;
	assign row_base     = AW'(32'(in_row) * MAX_DIM);
	assign load_addr    = row_base + AW'(in_col);
	assign elem_ext     = ELEMENT_BITS'(in_elem);

	// Sequencer and read address walk
	logic [EW-1:0]  k_q, klen_q;
	logic [AW-1:0]  a_addr_q, b_addr_q;
	logic           issue;
	logic           rd_v_s1, prod_v_s2;
	logic           out_free;
	logic [IDX_W-1:0] row_q, col_q;
	logic [ACC_W-1:0] acc_q;

	assign issue    = (state_q == ST_RUN) && (k_q < klen_q);
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			klen_q    <= '0;
			rd_v_s1   <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			rd_v_s1   <= issue;
			prod_v_s2 <= rd_v_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (do_compute) begin
						state_q <= ST_RUN;
						k_q     <= '0;
						klen_q  <= k_eff;
					end
				end
				ST_RUN: begin
					if (issue)
						k_q <= k_q + EW'(1);
					else if (!rd_v_s1 && !prod_v_s2)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and address counters
	always_ff @(posedge clk) begin
		if (do_compute) begin
			row_q    <= in_row;
			col_q    <= in_col;
			a_addr_q <= row_base;
			b_addr_q <= AW'(in_col);
		end else if (issue) begin
			a_addr_q <= a_addr_q + AW'(1);
			b_addr_q <= b_addr_q + AW'(MAX_DIM);
		end
	end

	// Element stores, registered reads
	logic [ELEMENT_BITS-1:0] a_mem [DEPTH];
	logic [ELEMENT_BITS-1:0] b_mem [DEPTH];
	logic signed [ELEMENT_BITS-1:0] a_rd_s1, b_rd_s1;

	always_ff @(posedge clk) begin
		if (do_load_a)
			a_mem[load_addr] <= elem_ext;
		a_rd_s1 <= a_mem[a_addr_q];
	end

	always_ff @(posedge clk) begin
		if (do_load_b)
			b_mem[load_addr] <= elem_ext;
		b_rd_s1 <= b_mem[b_addr_q];
	end

	// Shared multiplier, then accumulate
	logic signed [PW-1:0] prod_s2;

	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
	end

	always_ff @(posedge clk) begin
		if (do_compute)
			acc_q <= ACC_W'(in_acc);
		else if (prod_v_s2)
			acc_q <= acc_q + ACC_W'(prod_s2);
	end

	// Output register
	logic             m_tvalid_q;
	logic [IDX_W-1:0] res_row_q, res_col_q;
	logic [ACC_W-1:0] res_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (state_q == ST_DONE && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			res_row_q <= row_q;
			res_col_q <= col_q;
			res_val_q <= acc_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_DATA_W-2*IDX_W-ACC_W)'(0), res_val_q, res_col_q, res_row_q};

	// Checks
	`MMA_ASSERT(a_k_bound, clk, arst_n, (state_q == ST_RUN) |-> (k_q <= klen_q), "k past depth")
	`MMA_ASSERT(a_busy_stall, clk, arst_n, (state_q != ST_IDLE) |-> !s_tready, "ready while busy")
	`MMA_ASSERT_NEVER(a_done_drained, clk, arst_n,
		(state_q == ST_DONE) && (rd_v_s1 || prod_v_s2), "done with products in flight")
	`MMA_ASSERT(a_out_from_done, clk, arst_n,
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_DONE), "result without compute")

endmodule

>>> sim/matrix_multiply_accumulate_check.sv
`timescale 1ns / 1ps

// Watches the input, output and register ports, keeps a copy of both
// element stores and the dimensions, and compares every result beat.
module matrix_multiply_accumulate_check
	import mma_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
	input  logic [IN_DATA_W-1:0]  s_tdata,   // row, column, element, acc_in, zero pad
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,   // result_row, result_column,
	                                         // result_value, zero pad
	input  logic                  cfg_we,
	input  logic [REG_W-1:0]      cfg_index,
	input  logic [DIM_W-1:0]      cfg_data,
	output int                    fail_count,
	output int                    waiting
);

	localparam int STORE_DIM = MAX_DIM_DEF;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [ACC_W-1:0] value;
	} c_element_t;

	// Shadow copies of the element stores and the dimension registers
	logic [VAL_W-1:0] a_elems [0:STORE_DIM*STORE_DIM-1];
	logic [VAL_W-1:0] b_elems [0:STORE_DIM*STORE_DIM-1];
	logic [DIM_W-1:0] rows_cfg;
	logic [DIM_W-1:0] cols_cfg;
	logic [DIM_W-1:0] depth_cfg;

	c_element_t       c_due [$];
	c_element_t       c_head;
	int               failures = 0;
	int               due_count = 0;

	cmd_t             in_cmd;
	logic [IDX_W-1:0] in_row;
	logic [IDX_W-1:0] in_col;
	logic [VAL_W-1:0] in_elem;
	logic [ACCIN_W-1:0] in_acc;

	assign fail_count = failures;
	assign waiting    = due_count;

	function automatic int clip_dim(logic [DIM_W-1:0] d);
		return (d > STORE_DIM) ? STORE_DIM : int'(d);
	endfunction

	// acc_in plus the dot product of row i of A and column j of B, wrapped to 40 bits
	function automatic logic [ACC_W-1:0] mac_element(logic [IDX_W-1:0] i,
			logic [IDX_W-1:0] j, logic [ACCIN_W-1:0] acc_in);
		longint total;
		longint a_val;
		longint b_val;
		int     depth;
		depth = clip_dim(depth_cfg);
		total = longint'($signed(acc_in));
		for (int k = 0; k < depth; k++) begin
			a_val = longint'($signed(a_elems[int'(i) * STORE_DIM + k]));
			b_val = longint'($signed(b_elems[k * STORE_DIM + int'(j)]));
			total = total + a_val * b_val;
		end
		return total[ACC_W-1:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
			input logic [ACC_W-1:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg  = 7'd64;
			cols_cfg  = 7'd64;
			depth_cfg = 7'd64;
			c_due.delete();
			due_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS_OF_A:    rows_cfg = cfg_data;
					REG_COLUMNS_OF_B: cols_cfg = cfg_data;
					REG_INNER_DEPTH:  depth_cfg = cfg_data;
					default: ;
				endcase
			end

			// result beat against the oldest expected element
			if (m_tvalid && m_tready) begin
				if (c_due.size() == 0) begin
					report_mismatch("unexpected result beat", m_tdata[51:12], '0);
				end else begin
					c_head = c_due.pop_front();
					if (m_tdata[5:0] !== c_head.row)
						report_mismatch("result_row", ACC_W'(m_tdata[5:0]),
							ACC_W'(c_head.row));
					if (m_tdata[11:6] !== c_head.col)
						report_mismatch("result_column", ACC_W'(m_tdata[11:6]),
							ACC_W'(c_head.col));
					if (m_tdata[51:12] !== c_head.value)
						report_mismatch("result_value", m_tdata[51:12], c_head.value);
					if (m_tdata[55:52] !== 4'd0)
						report_mismatch("result pad", ACC_W'(m_tdata[55:52]), '0);
				end
			end

			// input beat: update the stores or queue the computed element
			if (s_tvalid && s_tready) begin
				in_cmd  = s_tuser;
				in_row  = s_tdata[5:0];
				in_col  = s_tdata[11:6];
				in_elem = s_tdata[27:12];
				in_acc  = s_tdata[59:28];
				case (in_cmd)
					CMD_LOAD_A: a_elems[int'(in_row) * STORE_DIM + int'(in_col)] = in_elem;
					CMD_LOAD_B: b_elems[int'(in_row) * STORE_DIM + int'(in_col)] = in_elem;
					CMD_COMPUTE: begin
						if (in_row < clip_dim(rows_cfg) && in_col < clip_dim(cols_cfg))
							c_due.push_back('{in_row, in_col,
								mac_element(in_row, in_col, in_acc)});
					end
					default: ;
				endcase
			end
			due_count <= c_due.size();
		end
	end

endmodule

>>> sim/matrix_multiply_accumulate_test.sv
`timescale 1ns / 1ps

module matrix_multiply_accumulate_test
	import mma_pkg::*;
();

	localparam int STORE_DIM     = MAX_DIM_DEF;
	localparam int HOLD_CYCLES   = 500;
	localparam int SETTLE_CYCLES = 80;
	localparam int STALL_LIMIT   = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [CMD_W-1:0]      s_tuser = '0;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [REG_W-1:0]      cfg_index = '0;
	logic [DIM_W-1:0]      cfg_data = '0;

	int fail_count;
	int waiting;
	int quiet_cycles = 0;
	int beats_sent = 0;
	int m_eff;
	int n_eff;
	int k_eff;
	bit calm = 1'b0;
	bit hold_request = 1'b0;

	// entries written since reset, so no compute reads an undefined element
	bit a_written [0:STORE_DIM*STORE_DIM-1];
	bit b_written [0:STORE_DIM*STORE_DIM-1];

	always #6 clk = ~clk;

	matrix_multiply_accumulate DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	matrix_multiply_accumulate_check mac_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.waiting    (waiting)
	);

	// mostly short gaps, a few long ones, none in calm phases
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// favor the first and last row or column so stores get reused
	function automatic int pick_index(int dim);
		int r;
		r = $urandom_range(0, 99);
		if (dim == 0)
			return $urandom_range(0, STORE_DIM - 1);
		if (r < 30)
			return 0;
		if (r < 60)
			return dim - 1;
		return $urandom_range(0, dim - 1);
	endfunction

	function automatic logic [VAL_W-1:0] rand_element();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'h7FFF;
		if (r < 20)
			return 16'h8000;
		if (r < 25)
			return 16'h0000;
		return VAL_W'($urandom);
	endfunction

	function automatic logic [ACCIN_W-1:0] rand_acc();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 32'h7FFF_FFFF;
		if (r < 20)
			return 32'h8000_0000;
		return $urandom;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_beat(int row, int col,
			logic [VAL_W-1:0] elem, logic [ACCIN_W-1:0] acc);
		logic [IDX_W-1:0] r6;
		logic [IDX_W-1:0] c6;
		r6 = row[IDX_W-1:0];
		c6 = col[IDX_W-1:0];
		return {4'd0, acc, elem, c6, r6};
	endfunction

	// one input beat; valid stays high into the next call unless a gap is taken
	task automatic send_beat(input cmd_t cmd, input logic [IN_DATA_W-1:0] data);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (cmd != CMD_UNUSED)
			beats_sent++;
	endtask

	task automatic send_load(input cmd_t cmd, input int row, input int col,
			input logic [VAL_W-1:0] elem);
		if (cmd == CMD_LOAD_A)
			a_written[row * STORE_DIM + col] = 1'b1;
		else
			b_written[row * STORE_DIM + col] = 1'b1;
		send_beat(cmd, pack_beat(row, col, elem, $urandom));
	endtask

	// loads any missing element of row i of A and column j of B, then computes
	task automatic issue_compute(input int i, input int j, input logic [ACCIN_W-1:0] acc);
		if (i < m_eff && j < n_eff) begin
			for (int k = 0; k < k_eff; k++) begin
				if (!a_written[i * STORE_DIM + k])
					send_load(CMD_LOAD_A, i, k, rand_element());
				if (!b_written[k * STORE_DIM + j])
					send_load(CMD_LOAD_B, k, j, rand_element());
			end
		end
		send_beat(CMD_COMPUTE, pack_beat(i, j, VAL_W'($urandom), acc));
	endtask

	// sender goes quiet until every expected result has been taken
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[DIM_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_dims(input int m, input int n, input int k);
		write_reg(REG_ROWS_OF_A, m);
		write_reg(REG_COLUMNS_OF_B, n);
		write_reg(REG_INNER_DEPTH, k);
		cfg_we <= 1'b0;
		m_eff = (m > STORE_DIM) ? STORE_DIM : m;
		n_eff = (n > STORE_DIM) ? STORE_DIM : n;
		k_eff = (k > STORE_DIM) ? STORE_DIM : k;
	endtask

	// random mix: mostly computes with their loads, plus overwrites,
	// out-of-range computes and the unused command
	task automatic run_mix(input int m, input int n, input int k, input int count);
		int target;
		int r;
		int row;
		set_dims(m, n, k);
		target = beats_sent + count;
		while (beats_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				issue_compute(pick_index(m_eff), pick_index(n_eff), rand_acc());
			end else if (r < 50) begin
				issue_compute($urandom_range(0, 63), $urandom_range(0, 63), rand_acc());
			end else if (r < 62) begin
				send_load(CMD_LOAD_A, $urandom_range(0, 63), $urandom_range(0, 63),
					rand_element());
			end else if (r < 74) begin
				send_load(CMD_LOAD_B, $urandom_range(0, 63), $urandom_range(0, 63),
					rand_element());
			end else if (r < 82) begin
				send_load(CMD_LOAD_A, pick_index(m_eff), pick_index(k_eff), rand_element());
			end else if (r < 90) begin
				send_load(CMD_LOAD_B, pick_index(k_eff), pick_index(n_eff), rand_element());
			end else if (r < 94) begin
				send_beat(CMD_UNUSED, {4'd0, 60'($urandom) << 28 | 60'($urandom)});
			end else begin
				row = (m_eff < STORE_DIM) ? $urandom_range(m_eff, 63) : pick_index(m_eff);
				issue_compute(row, $urandom_range(0, 63), rand_acc());
			end
		end
		drain_results();
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// no beat or register write for too long means the block hung
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme elements and accumulators, far indices,
		// unused command, computes outside C
		set_dims(2, 2, 2);
		send_load(CMD_LOAD_A, 0, 0, 16'h7FFF);
		send_load(CMD_LOAD_A, 0, 1, 16'h8000);
		send_load(CMD_LOAD_B, 0, 0, 16'h8000);
		send_load(CMD_LOAD_B, 1, 0, 16'h7FFF);
		issue_compute(0, 0, 32'h7FFF_FFFF);
		issue_compute(0, 0, 32'h8000_0000);
		send_load(CMD_LOAD_A, 1, 0, 16'h0100);
		send_load(CMD_LOAD_A, 1, 1, 16'hFFFF);
		send_load(CMD_LOAD_B, 0, 1, 16'hFFFF);
		send_load(CMD_LOAD_B, 1, 1, 16'h8000);
		issue_compute(1, 1, 32'h0000_0000);
		issue_compute(1, 0, 32'hFFFF_FFFF);
		issue_compute(0, 1, 32'h8000_0000);
		send_load(CMD_LOAD_A, 63, 63, 16'h5A5A);
		send_load(CMD_LOAD_B, 63, 63, 16'hA5A5);
		send_beat(CMD_UNUSED, {4'd0, {60{1'b1}}});
		issue_compute(2, 0, 32'h1234_5678);
		issue_compute(0, 2, 32'h1234_5678);
		issue_compute(63, 63, 32'h7FFF_FFFF);
		drain_results();

		// block fills up behind a long output hold, then a pause mid-stream
		hold_request = 1'b1;
		run_mix(4, 4, 8, 40);
		run_mix(4, 4, 8, 40);

		// zero depth, then empty C
		run_mix(3, 3, 0, 40);
		run_mix(0, 5, 4, 20);
		run_mix(5, 0, 4, 20);

		// registers above the store size, then the largest legal size
		calm = 1'b1;
		run_mix(127, 127, 127, 120);
		calm = 1'b0;
		run_mix(64, 64, 64, 100);
		run_mix(1, 1, 1, 40);
		run_mix(1, 64, 2, 40);

		for (int p = 0; p < 4; p++) begin
			calm = (p == 1);
			run_mix($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8), 70);
		end
		calm = 1'b0;

		drain_results();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/mma_pkg.sv
rtl/core/matrix_multiply_accumulate.sv
sim/matrix_multiply_accumulate_check.sv
sim/matrix_multiply_accumulate_test.sv
